[design/tremolo_amplitude_modulator_macros.svh]
// ----------------------------------------------------------------------------
// tremolo amplitude modulator assertion macros
// shorthand for clocked implications used by the port checker
// ----------------------------------------------------------------------------
`ifndef TREMOLO_AMPLITUDE_MODULATOR_MACROS_SVH
`define TREMOLO_AMPLITUDE_MODULATOR_MACROS_SVH

// same-cycle implication, checked while out of reset
`define TAM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tam check failed");

// next-cycle implication, checked while out of reset
`define TAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tam check failed");

// same-cycle implication, checked at every edge including reset
`define TAM_ASSERT_ALWAYS(label, clk, ante, cons) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("tam check failed");

`endif

[design/tam_pkg.sv]
// ----------------------------------------------------------------------------
// tam_pkg
// shared types and fixed-point constants of the tremolo amplitude modulator
// ----------------------------------------------------------------------------
package tam_pkg;

	localparam int PHASE_BITS_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int DIV_NB = 64;
	localparam int DIV_DB = 36;
	localparam int DIV_CW = $clog2(DIV_NB);

	localparam int IQ_DEPTH = 4;
	localparam int OQ_DEPTH = 2;

	localparam logic [32:0] Q30_ONE   = 33'd1073741824;
	localparam logic [32:0] HALF_PI   = 33'd1686629713;
	localparam logic [32:0] SIN_A     = 33'd1686629713;
	localparam logic [32:0] SIN_B     = 33'd688904866;
	localparam logic [32:0] SIN_C     = 33'd76016977;
	localparam logic [32:0] AT_C1     = 33'd1073597943;
	localparam logic [32:0] AT_C3     = 33'd354656387;
	localparam logic [32:0] AT_C5     = 33'd193424926;
	localparam logic [32:0] AT_C7     = 33'd91410863;
	localparam logic [32:0] AT_C9     = 33'd22371518;
	localparam logic [32:0] GAIN_K    = 33'd123619096;
	localparam logic [32:0] RECIP3    = 33'd2863311531;
	localparam logic [16:0] SHAPE_MIN = 17'd3277;
	localparam logic [16:0] UNITY_Q16 = 17'd65536;

	typedef enum logic [1:0] {
		REG_RATE  = 2'd0,
		REG_DEPTH = 2'd1,
		REG_SHAPE = 2'd2,
		REG_SRATE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  rate;
		logic [16:0] depth;
		logic [16:0] shape;
		logic [17:0] srate;
	} cfg_t;

	typedef struct packed {
		logic                start;
		logic [DIV_NB-1:0]   num;
		logic [DIV_DB-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_NB-1:0]   quot;
	} div_rsp_t;

endpackage

[design/tam_fifo.sv]
// ----------------------------------------------------------------------------
// tam_fifo
// small first-in first-out queue in flops with full and empty flags
// ----------------------------------------------------------------------------
module tam_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int PW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= wptr_q + 1'b1;
			if (do_rd) rptr_q <= rptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wdata;
	end
endmodule

[design/tam_front.sv]
// ----------------------------------------------------------------------------
// tam_front
// takes input transactions, splits each sample into sign and magnitude
// ----------------------------------------------------------------------------
module tam_front #(
	parameter int SAMPLE_BITS = tam_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic                   block_end_in,
	output logic                   full,
	output logic                   item_valid,
	input  logic                   item_pop,
	output logic [SAMPLE_BITS+1:0] item_data
);
	import tam_pkg::*;

	logic                   neg;
	logic [SAMPLE_BITS-1:0] mag;
	logic                   q_empty;

	assign neg = in_sample[SAMPLE_BITS-1];
	assign mag = neg ? (~in_sample + 1'b1) : in_sample;
	assign item_valid = !q_empty;

	tam_fifo #(.W(SAMPLE_BITS+2), .DEPTH(IQ_DEPTH)) u_iq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata ({block_end_in, neg, mag}),
		.full  (full),
		.rd    (item_pop),
		.rdata (item_data),
		.empty (q_empty)
	);
endmodule

[design/tam_div.sv]
// ----------------------------------------------------------------------------
// tam_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tam_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tam_pkg::div_req_t  req,
	output tam_pkg::div_rsp_t  rsp
);
	import tam_pkg::*;

	logic              busy_q, done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NB-1:0] num_q, quot_q;
	logic [DIV_DB-1:0] den_q, rem_q;
	logic [DIV_DB:0]   rem_sh, diff;
	logic              ge;

	assign rem_sh = {rem_q, num_q[DIV_NB-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = (rem_sh >= {1'b0, den_q});
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NB-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIV_NB-2:0], 1'b0};
			rem_q  <= ge ? diff[DIV_DB-1:0] : rem_sh[DIV_DB-1:0];
			quot_q <= {quot_q[DIV_NB-2:0], ge};
		end
	end
endmodule

[design/tam_back.sv]
// ----------------------------------------------------------------------------
// tam_back
// sequencer that runs oscillator, gain and output rounding on one shared
// multiplier and the shared divider, and advances the phase
// ----------------------------------------------------------------------------
module tam_back #(
	parameter int PHASE_BITS  = tam_pkg::PHASE_BITS_DEF,
	parameter int SAMPLE_BITS = tam_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tam_pkg::cfg_t          cfg,
	input  logic                   item_valid,
	output logic                   item_pop,
	input  logic [SAMPLE_BITS+1:0] item_data,
	input  logic                   res_full,
	output logic                   res_push,
	output logic [SAMPLE_BITS:0]   res_data
);
	import tam_pkg::*;

	localparam int SB = SAMPLE_BITS;

	typedef enum logic [25:0] {
		S_IDLE = 26'd1 << 0,  S_SX2 = 26'd1 << 1,  S_ST1 = 26'd1 << 2,
		S_ST2  = 26'd1 << 3,  S_SSN = 26'd1 << 4,  S_DY  = 26'd1 << 5,
		S_ARNG = 26'd1 << 6,  S_DBIG = 26'd1 << 7, S_AX2 = 26'd1 << 8,
		S_A9   = 26'd1 << 9,  S_A7  = 26'd1 << 10, S_A5  = 26'd1 << 11,
		S_A3   = 26'd1 << 12, S_ARES = 26'd1 << 13, S_DDEN = 26'd1 << 14,
		S_DLFO = 26'd1 << 15, S_GZ  = 26'd1 << 16, S_G3  = 26'd1 << 17,
		S_G3D  = 26'd1 << 18, S_G2  = 26'd1 << 19, S_G1  = 26'd1 << 20,
		S_MOD  = 26'd1 << 21, S_FAC = 26'd1 << 22, S_RND = 26'd1 << 23,
		S_DINC = 26'd1 << 24, S_OUT = 26'd1 << 25
	} state_t;

	state_t state_q;
	logic   mph_q;

	logic [PHASE_BITS-1:0] phase_q;
	logic [31:0]           ang;
	logic [30:0]           x_c;

	logic [16:0] shape_c, depth_c;
	logic [21:0] dnm;

	logic [32:0] mul_a, mul_b;
	logic [65:0] p_q;
	logic [32:0] sh30, rr;
	logic [65:0] rsum;
	logic [35:0] r_c;
	logic [35:0] sbit;

	logic [30:0] x2_q, xa_q, num_q, g_q, m_q, f_q;
	logic [32:0] t_q;
	logic [34:0] ya_q;
	logic [26:0] z_q;
	logic [31:0] u_q;
	logic        big_q, asel_q, neg_q, be_q;
	logic [SB-1:0] mag_q, res_q;
	logic [30:0] lmag;

	div_req_t dreq;
	div_rsp_t drsp;

	generate
		if (PHASE_BITS >= 32) begin : g_ang_hi
			assign ang = phase_q[PHASE_BITS-1 -: 32];
		end else begin : g_ang_lo
			assign ang = {phase_q, {(32-PHASE_BITS){1'b0}}};
		end
	endgenerate

	assign x_c = ang[30] ? (31'(Q30_ONE) - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};

	assign shape_c = (cfg.shape < SHAPE_MIN) ? SHAPE_MIN :
		(cfg.shape > UNITY_Q16) ? UNITY_Q16 : cfg.shape;
	assign depth_c = (cfg.depth > UNITY_Q16) ? UNITY_Q16 : cfg.depth;
	assign dnm = {1'b0, cfg.srate, 3'b0} + {3'b0, cfg.srate, 1'b0};

	assign sh30 = p_q[62:30];
	assign rr   = big_q ? (HALF_PI - sh30) : sh30;
	assign rsum = p_q + (66'd1 << 29);
	assign r_c  = rsum[65:30];
	assign sbit = 36'd1 << (SB-1);
	assign lmag = (drsp.quot > 64'(Q30_ONE)) ? 31'(Q30_ONE) : drsp.quot[30:0];

	assign item_pop = (state_q == S_IDLE) && item_valid;
	assign res_push = (state_q == S_OUT) && !res_full;
	assign res_data = {be_q, res_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		dreq  = '0;
		unique case (state_q) inside
			S_SX2:  begin mul_a = 33'(x_c);  mul_b = 33'(x_c);  end
			S_ST1:  begin mul_a = 33'(x2_q); mul_b = SIN_C;      end
			S_ST2:  begin mul_a = 33'(x2_q); mul_b = t_q;        end
			S_SSN:  begin
				mul_a = 33'(x_c); mul_b = t_q;
				dreq.start = mph_q;
				dreq.num   = 64'(sh30) << 16;
				dreq.den   = 36'(shape_c);
			end
			S_ARNG: begin
				dreq.start = (ya_q > 35'(Q30_ONE));
				dreq.num   = 64'd1 << 60;
				dreq.den   = 36'(ya_q);
			end
			S_AX2:  begin mul_a = 33'(xa_q); mul_b = 33'(xa_q); end
			S_A9:   begin mul_a = 33'(x2_q); mul_b = AT_C9;      end
			S_A7, S_A5, S_A3: begin mul_a = 33'(x2_q); mul_b = t_q; end
			S_ARES: begin
				mul_a = 33'(xa_q); mul_b = t_q;
				dreq.start = mph_q;
				dreq.num   = asel_q ? {3'b0, num_q, 30'b0} : (64'd1 << 46);
				dreq.den   = asel_q ? 36'(rr) : 36'(shape_c);
			end
			S_GZ:   begin mul_a = 33'(shape_c); mul_b = GAIN_K;  end
			S_G3, S_G2, S_G1: begin mul_a = 33'(z_q); mul_b = t_q; end
			S_G3D:  begin mul_a = t_q;           mul_b = RECIP3;  end
			S_MOD:  begin mul_a = 33'(depth_c); mul_b = 33'(u_q); end
			S_FAC:  begin mul_a = 33'(m_q);     mul_b = 33'(g_q); end
			S_RND:  begin
				mul_a = 33'(mag_q); mul_b = 33'(f_q);
				dreq.start = mph_q && (dnm != '0);
				dreq.num   = 64'(cfg.rate) << PHASE_BITS;
				dreq.den   = 36'(dnm);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= 66'(mul_a) * 66'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mph_q   <= 1'b0;
			phase_q <= '0;
		end else begin
			unique case (state_q) inside
				S_IDLE: if (item_valid) state_q <= S_SX2;
				S_SX2, S_ST1, S_ST2, S_SSN, S_AX2, S_A9, S_A7, S_A5, S_A3, S_ARES,
				S_GZ, S_G3, S_G3D, S_G2, S_G1, S_MOD, S_FAC, S_RND: begin
					mph_q <= !mph_q;
					if (mph_q) begin
						unique case (state_q)
							S_SX2:  state_q <= S_ST1;
							S_ST1:  state_q <= S_ST2;
							S_ST2:  state_q <= S_SSN;
							S_SSN:  state_q <= S_DY;
							S_AX2:  state_q <= S_A9;
							S_A9:   state_q <= S_A7;
							S_A7:   state_q <= S_A5;
							S_A5:   state_q <= S_A3;
							S_A3:   state_q <= S_ARES;
							S_ARES: state_q <= asel_q ? S_DLFO : S_DDEN;
							S_GZ:   state_q <= S_G3;
							S_G3:   state_q <= S_G3D;
							S_G3D:  state_q <= S_G2;
							S_G2:   state_q <= S_G1;
							S_G1:   state_q <= S_MOD;
							S_MOD:  state_q <= S_FAC;
							S_FAC:  state_q <= S_RND;
							S_RND:  state_q <= (dnm != '0) ? S_DINC : S_OUT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DY:   if (drsp.done) state_q <= S_ARNG;
				S_ARNG: state_q <= (ya_q > 35'(Q30_ONE)) ? S_DBIG : S_AX2;
				S_DBIG: if (drsp.done) state_q <= S_AX2;
				S_DDEN: if (drsp.done) state_q <= S_ARNG;
				S_DLFO: if (drsp.done) state_q <= S_GZ;
				S_DINC: if (drsp.done) begin
					phase_q <= phase_q + drsp.quot[PHASE_BITS-1:0];
					state_q <= S_OUT;
				end
				S_OUT:  if (!res_full) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (item_valid) begin
				mag_q <= item_data[SB-1:0];
				neg_q <= item_data[SB];
				be_q  <= item_data[SB+1];
			end
			S_SX2:  if (mph_q) x2_q <= p_q[60:30];
			S_ST1:  if (mph_q) t_q <= SIN_B - sh30;
			S_ST2:  if (mph_q) t_q <= SIN_A - sh30;
			S_DY:   if (drsp.done) begin
				ya_q   <= drsp.quot[34:0];
				asel_q <= 1'b0;
			end
			S_ARNG: begin
				big_q <= (ya_q > 35'(Q30_ONE));
				xa_q  <= ya_q[30:0];
			end
			S_DBIG: if (drsp.done) xa_q <= drsp.quot[30:0];
			S_AX2:  if (mph_q) x2_q <= p_q[60:30];
			S_A9:   if (mph_q) t_q <= AT_C7 - sh30;
			S_A7:   if (mph_q) t_q <= AT_C5 - sh30;
			S_A5:   if (mph_q) t_q <= AT_C3 - sh30;
			S_A3:   if (mph_q) t_q <= AT_C1 - sh30;
			S_ARES: if (mph_q && !asel_q) num_q <= rr[30:0];
			S_DDEN: if (drsp.done) begin
				ya_q   <= drsp.quot[34:0];
				asel_q <= 1'b1;
			end
			S_DLFO: if (drsp.done) begin
				u_q <= ang[31] ? (32'(Q30_ONE) - 32'(lmag)) : (32'(Q30_ONE) + 32'(lmag));
			end
			S_GZ:   if (mph_q) begin
				z_q <= p_q[42:16];
				t_q <= Q30_ONE + 33'(p_q[42:18]);
			end
			S_G3:   if (mph_q) t_q <= sh30;
			S_G3D:  if (mph_q) t_q <= Q30_ONE + p_q[65:33];
			S_G2:   if (mph_q) t_q <= Q30_ONE + (sh30 >> 1);
			S_G1:   if (mph_q) g_q <= 31'(Q30_ONE + sh30);
			S_MOD:  if (mph_q) m_q <= 31'(49'(Q30_ONE) - p_q[65:17]);
			S_FAC:  if (mph_q) f_q <= sh30[30:0];
			S_RND:  if (mph_q) begin
				if (neg_q) res_q <= (r_c > sbit) ? SB'(-sbit) : SB'(-r_c);
				else res_q <= (r_c > sbit - 1'b1) ? SB'(sbit - 1'b1) : SB'(r_c);
			end
			default: ;
		endcase
	end

	tam_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);
endmodule

[design/tremolo_amplitude_modulator.sv]
// ----------------------------------------------------------------------------
// tremolo_amplitude_modulator
// audio tremolo: sample times a shaped-oscillator gain and a makeup gain
//
// channel   direction  handshake            payload
// input     in         push / full          in_sample, block_end_in
// result    out        empty / pop          out_sample, block_end_out
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one sample takes three to six passes of the 64-step bit-serial divider,
// twenty-four multiplier steps and the idle, range and output states
// a four-entry input queue and a two-entry result queue decouple both sides
// reset clears queues, sequencer and phase; registers return to defaults
// ----------------------------------------------------------------------------
module tremolo_amplitude_modulator #(
	parameter int PHASE_BITS  = tam_pkg::PHASE_BITS_DEF,
	parameter int SAMPLE_BITS = tam_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic                   block_end_in,
	output logic                   empty,
	input  logic                   pop,
	output logic [SAMPLE_BITS-1:0] out_sample,
	output logic                   block_end_out,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [17:0]            cfg_data
);
	import tam_pkg::*;

	cfg_t cfg_q;

	logic                   item_valid, item_pop;
	logic [SAMPLE_BITS+1:0] item_data;
	logic                   res_full, res_push;
	logic [SAMPLE_BITS:0]   res_data, oq_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate  <= 8'd50;
			cfg_q.depth <= 17'd52429;
			cfg_q.shape <= 17'd32768;
			cfg_q.srate <= 18'd48000;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RATE:  cfg_q.rate  <= cfg_data[7:0];
				REG_DEPTH: cfg_q.depth <= cfg_data[16:0];
				REG_SHAPE: cfg_q.shape <= cfg_data[16:0];
				REG_SRATE: cfg_q.srate <= cfg_data;
				default: ;
			endcase
		end
	end

	tam_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.in_sample   (in_sample),
		.block_end_in(block_end_in),
		.full        (full),
		.item_valid  (item_valid),
		.item_pop    (item_pop),
		.item_data   (item_data)
	);

	tam_back #(.PHASE_BITS(PHASE_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item_valid(item_valid),
		.item_pop  (item_pop),
		.item_data (item_data),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	tam_fifo #(.W(SAMPLE_BITS+1), .DEPTH(OQ_DEPTH)) u_oq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res_data),
		.full  (res_full),
		.rd    (pop),
		.rdata (oq_data),
		.empty (empty)
	);

	assign out_sample    = oq_data[SAMPLE_BITS-1:0];
	assign block_end_out = oq_data[SAMPLE_BITS];
endmodule

[design/tam_checker.sv]
// ----------------------------------------------------------------------------
// tam_checker
// port-level checks on reset state and held results
// ----------------------------------------------------------------------------
`include "tremolo_amplitude_modulator_macros.svh"

module tam_checker #(
	parameter int SAMPLE_BITS = tam_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   full,
	input logic                   empty,
	input logic                   pop,
	input logic [SAMPLE_BITS-1:0] out_sample,
	input logic                   block_end_out
);
	`TAM_ASSERT_ALWAYS(a_reset_clear, clk, !arst_n, empty && !full)
	`TAM_ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty)
	`TAM_ASSERT_NEXT(a_result_stable, clk, arst_n, !empty && !pop,
		$stable(out_sample) && $stable(block_end_out))
endmodule

bind tremolo_amplitude_modulator tam_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tam_checker (.*);
